/* hdl/tfbm_pkg.sv */
// Package for the tileable fBm value noise block: widths, hash constants,
// register indexes and shared types. No dependencies.
`default_nettype none
package tfbm_pkg;

   // Field and datapath widths
   localparam int TEXEL_W    = 9;
   localparam int BASE_W     = 7;
   localparam int OCT_W      = 4;
   localparam int FRAC_W     = 10;
   localparam int PROD_W     = TEXEL_W + 1 + BASE_W;
   localparam int HASH_W     = 32;
   localparam int CORNER_W   = 16;
   localparam int WEIGHT_W   = 17;
   localparam int ROW_W      = 32;
   localparam int BLEND_W    = 48;
   localparam int NOISE_W    = 16;
   localparam int SCALE_SHIFT = 32;
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int OCT_LAT    = 6;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_COUNT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OCTAVES    = 4'd1;
   localparam logic [BASE_W-1:0] BASE_COUNT_RESET = 7'd12;
   localparam logic [OCT_W-1:0]  OCTAVES_RESET    = 4'd5;

   // Parameter defaults
   localparam int TILE_SIZE_DEF   = 512;
   localparam int MAX_OCTAVES_DEF = 8;

   // Lattice hash multipliers
   localparam logic [HASH_W-1:0] HASH_KX = 32'd374761393;
   localparam logic [HASH_W-1:0] HASH_KY = 32'd668265263;
   localparam logic [HASH_W-1:0] HASH_KM = 32'd1274126177;

   // Per-axis coordinate handed to every octave lane
   typedef struct packed {
      logic [PROD_W-1:0] prod;  // (2t+1) * base cells
      logic [BASE_W-1:0] rem;   // (prod >> (log2 tile + 1)) mod base cells
   } axis_type;

endpackage
`default_nettype wire

/* hdl/tfbm_octave.sv */
// One octave lane: lattice corners, hash, smoothstep weights and bilinear blend.
// Six register stages. Depends on tfbm_pkg.
`default_nettype none
module tfbm_octave #(
   parameter int TILE_SIZE   = tfbm_pkg::TILE_SIZE_DEF,
   parameter int MAX_OCTAVES = tfbm_pkg::MAX_OCTAVES_DEF,
   parameter int OCT_IDX     = 0
) (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [tfbm_pkg::BASE_W-1:0]   base_count,
   input  wire tfbm_pkg::axis_type            axis_x,
   input  wire tfbm_pkg::axis_type            axis_y,
   output logic [tfbm_pkg::BLEND_W-1:0]       blend
);
   localparam int TILE_LOG = $clog2(TILE_SIZE);
   localparam int CELL_W   = tfbm_pkg::BASE_W + MAX_OCTAVES - 1;
   localparam int WIDE_W   = tfbm_pkg::PROD_W + tfbm_pkg::FRAC_W + MAX_OCTAVES - 1;
   localparam int FW = tfbm_pkg::FRAC_W;
   localparam int HW = tfbm_pkg::HASH_W;
   localparam int WW = tfbm_pkg::WEIGHT_W;

   tfbm_pkg::axis_type axis [2];
   logic [WIDE_W-1:0] pos [2];
   logic [CELL_W-1:0] cells;
   logic [CELL_W-1:0] low_mask;
   logic [CELL_W-1:0] c0 [2];
   logic [CELL_W-1:0] c0_inc [2];

   // Stage registers
   logic [CELL_W-1:0] coord_ff [2][2];
   logic [CELL_W-1:0] coord_in [2][2];
   logic [FW-1:0]     frac_ff  [2];
   logic [FW-1:0]     frac_in  [2];
   logic [HW-1:0]     kx_ff [2], kx_in [2];
   logic [HW-1:0]     ky_ff [2], ky_in [2];
   logic [2*FW-1:0]   fsq_ff [2], fsq_in [2];
   logic [FW+1:0]     lin_ff [2], lin_in [2];
   logic [HW-1:0]     mix_ff [4], mix_in [4];
   logic [HW-1:0]     smooth [2];
   logic [HW-1:0]     sum_k [4];
   logic [WW-1:0]     w3_ff [2], w3_in [2];
   logic [WW-1:0]     w4_ff [2];
   logic [HW-1:0]     hash_ff [4], hash_in [4];
   logic [tfbm_pkg::CORNER_W-1:0] corner [4];
   logic [WW-1:0]     wix;
   logic [tfbm_pkg::ROW_W-1:0] row_ff [2], row_in [2];
   logic [WW-1:0]     wy5_ff;
   logic [WW-1:0]     wiy;
   logic [tfbm_pkg::BLEND_W-1:0] blend_ff, blend_in;

   assign axis[0] = axis_x;
   assign axis[1] = axis_y;
   assign cells    = CELL_W'(base_count) << OCT_IDX;
   assign low_mask = (CELL_W'(1) << OCT_IDX) - CELL_W'(1);

   // Cell position, fraction and wrapped corner indexes
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         pos[a]         = (WIDE_W'(axis[a].prod) << (FW + OCT_IDX)) >> (TILE_LOG + 1);
         frac_in[a]     = pos[a][FW-1:0];
         c0[a]          = (CELL_W'(axis[a].rem) << OCT_IDX) | (pos[a][FW +: CELL_W] & low_mask);
         c0_inc[a]      = c0[a] + CELL_W'(1);
         coord_in[a][0] = c0[a];
         coord_in[a][1] = (c0_inc[a] == cells) ? '0 : c0_inc[a];
      end
   end

   // Hash multiplies and smoothstep square
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         kx_in[b]  = HW'(coord_ff[0][b]) * tfbm_pkg::HASH_KX;
         ky_in[b]  = HW'(coord_ff[1][b]) * tfbm_pkg::HASH_KY;
         fsq_in[b] = (2*FW)'(frac_ff[b]) * (2*FW)'(frac_ff[b]);
         lin_in[b] = (FW+2)'(3072) - (FW+2)'({frac_ff[b], 1'b0});
      end
   end

   // Mix corner sums, finish the smoothstep weight
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum_k[c]  = kx_ff[c % 2] + ky_ff[c / 2];
         mix_in[c] = sum_k[c] ^ (sum_k[c] >> 13);
      end
      for (int a = 0; a < 2; a++) begin
         smooth[a] = HW'(fsq_ff[a]) * HW'(lin_ff[a]);
         w3_in[a]  = WW'(((HW+1)'(smooth[a]) + (HW+1)'(8192)) >> 14);
      end
   end

   // Final hash multiply
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         hash_in[c] = mix_ff[c] * tfbm_pkg::HASH_KM;
      end
   end

   // Fold the hash to 16 bits and blend along x
   assign wix = WW'(17'h10000) - w4_ff[0];
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         corner[c] = hash_ff[c][15:0] ^ hash_ff[c][31:16];
      end
      for (int r = 0; r < 2; r++) begin
         row_in[r] = tfbm_pkg::ROW_W'(33'(corner[2*r]) * 33'(wix)
                                      + 33'(corner[2*r+1]) * 33'(w4_ff[0]));
      end
   end

   // Blend the two rows along y
   assign wiy = WW'(17'h10000) - wy5_ff;
   assign blend_in = tfbm_pkg::BLEND_W'(49'(row_ff[0]) * 49'(wiy) + 49'(row_ff[1]) * 49'(wy5_ff));

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (enable) begin
         coord_ff <= coord_in;
         frac_ff  <= frac_in;
         kx_ff    <= kx_in;
         ky_ff    <= ky_in;
         fsq_ff   <= fsq_in;
         lin_ff   <= lin_in;
         mix_ff   <= mix_in;
         w3_ff    <= w3_in;
         hash_ff  <= hash_in;
         w4_ff    <= w3_ff;
         row_ff   <= row_in;
         wy5_ff   <= w4_ff[1];
         blend_ff <= blend_in;
      end
   end

   assign blend = blend_ff;

endmodule
`default_nettype wire

/* hdl/tfbm_norm.sv */
// Octave weighting, registered adder tree and pipelined division by the total weight.
// Depends on tfbm_pkg.
`default_nettype none
module tfbm_norm #(
   parameter int MAX_OCTAVES = tfbm_pkg::MAX_OCTAVES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [tfbm_pkg::OCT_W-1:0]    octaves,
   input  wire logic [tfbm_pkg::BLEND_W-1:0]  blend [MAX_OCTAVES],
   output logic [tfbm_pkg::NOISE_W-1:0]       noise_level
);
   localparam int LV    = $clog2(MAX_OCTAVES);
   localparam int NP    = 1 << LV;
   localparam int SUM_W = tfbm_pkg::BLEND_W + MAX_OCTAVES;
   localparam int XW    = SUM_W + 1 - tfbm_pkg::SCALE_SHIFT;
   localparam int MW    = MAX_OCTAVES;
   localparam int QW    = tfbm_pkg::NOISE_W;
   localparam int SPS   = tfbm_pkg::DIV_STEPS_PER_STAGE;
   localparam int DS    = QW / SPS;
   localparam int OW    = tfbm_pkg::OCT_W;

   logic [SUM_W-1:0] leaf_in [NP];
   logic [SUM_W-1:0] tree_ff [LV+1][NP];
   logic [MW-1:0]    divisor;
   logic [SUM_W:0]   rounded;
   logic [XW-1:0]    xq_ff;
   logic [XW-1:0]    rem_ff  [DS];
   logic [QW-1:0]    quot_ff [DS];

   // Weight octave i by 2^(n-1-i); drop octaves past the count
   for (genvar i = 0; i < NP; i++) begin : g_leaf
      if (i < MAX_OCTAVES) begin : g_used
         assign leaf_in[i] = (OW'(i) < octaves)
            ? (SUM_W'(blend[i]) << (octaves - OW'(i) - OW'(1))) : '0;
      end else begin : g_pad
         assign leaf_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         tree_ff[0] <= leaf_in;
      end
   end

   // Registered pairwise adder tree
   for (genvar lv = 1; lv <= LV; lv++) begin : g_level
      always_ff @(posedge clock) begin
         if (enable) begin
            for (int j = 0; j < (NP >> lv); j++) begin
               tree_ff[lv][j] <= tree_ff[lv-1][2*j] + tree_ff[lv-1][2*j+1];
            end
         end
      end
   end

   // Round half up and drop the 2^32 scale
   assign divisor = (MW'(1) << octaves) - MW'(1);
   assign rounded = (SUM_W+1)'(tree_ff[LV][0])
                  + ((SUM_W+1)'(divisor) << (tfbm_pkg::SCALE_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (enable) begin
         xq_ff <= rounded[SUM_W:tfbm_pkg::SCALE_SHIFT];
      end
   end

   // Restoring division, a few quotient bits per stage
   for (genvar s = 0; s < DS; s++) begin : g_div
      logic [XW-1:0] rem_cur;
      logic [QW-1:0] quot_cur;
      logic [XW-1:0] trial;

      always_comb begin
         rem_cur  = (s == 0) ? xq_ff : rem_ff[(s == 0) ? 0 : s-1];
         quot_cur = (s == 0) ? '0 : quot_ff[(s == 0) ? 0 : s-1];
         trial    = '0;
         for (int t = 0; t < SPS; t++) begin
            trial = XW'(divisor) << (QW - 1 - s*SPS - t);
            if (rem_cur >= trial) begin
               rem_cur  = rem_cur - trial;
               quot_cur[QW - 1 - s*SPS - t] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s]  <= rem_cur;
            quot_ff[s] <= quot_cur;
         end
      end
   end

   // No octaves: force zero
   assign noise_level = (octaves == '0) ? '0 : quot_ff[DS-1];

endmodule
`default_nettype wire

/* hdl/tileable_fbm_value_noise_top.sv */
// Tileable fBm value noise, computed by the octave lanes and the bit-pair division pipeline.
// Throughput one texel per cycle; every stage advances together and holds while
// the result waits. TILE_SIZE must be a power of two.
// Synchronous active-high reset clears valid bits and loads base cells 12, 5 octaves.
`default_nettype none
module tileable_fbm_value_noise_top #(
   parameter int TILE_SIZE   = tfbm_pkg::TILE_SIZE_DEF,
   parameter int MAX_OCTAVES = tfbm_pkg::MAX_OCTAVES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [tfbm_pkg::TEXEL_W-1:0]      req_texel_x,
   input  wire logic [tfbm_pkg::TEXEL_W-1:0]      req_texel_y,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [tfbm_pkg::NOISE_W-1:0]           rsp_noise_level,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tfbm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tfbm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int TILE_LOG  = $clog2(TILE_SIZE);
   localparam int REM_STEPS = (TILE_LOG < tfbm_pkg::TEXEL_W) ? tfbm_pkg::TEXEL_W - TILE_LOG : 0;
   localparam int LAT = 4 + tfbm_pkg::OCT_LAT + $clog2(MAX_OCTAVES)
                      + tfbm_pkg::NOISE_W / tfbm_pkg::DIV_STEPS_PER_STAGE;
   localparam int PW  = tfbm_pkg::PROD_W;
   localparam int BW  = tfbm_pkg::BASE_W;
   localparam int OW  = tfbm_pkg::OCT_W;

   logic [BW-1:0]  base_count_ff;
   logic [OW-1:0]  octave_count_ff;
   logic [BW-1:0]  cells0;
   logic [OW-1:0]  octaves;
   logic           advance;
   logic [LAT-1:0] valid_ff;
   logic [LAT-1:0] valid_in;
   logic [PW-1:0]  prod_x_ff, prod_y_ff, prod_x_in, prod_y_in;
   logic [PW-1:0]  quo [2];
   logic [PW-1:0]  rem_work [2];
   tfbm_pkg::axis_type axis_ff [2];
   tfbm_pkg::axis_type axis_in [2];
   logic [tfbm_pkg::BLEND_W-1:0] blend [MAX_OCTAVES];

   // Configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_count_ff   <= tfbm_pkg::BASE_COUNT_RESET;
         octave_count_ff <= tfbm_pkg::OCTAVES_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tfbm_pkg::REG_BASE_COUNT: base_count_ff   <= csr_wdata[BW-1:0];
            tfbm_pkg::REG_OCTAVES:    octave_count_ff <= csr_wdata[OW-1:0];
            default: ;
         endcase
      end
   end

   assign cells0  = (base_count_ff == '0) ? BW'(1) : base_count_ff;
   assign octaves = (octave_count_ff > OW'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES) : octave_count_ff;

   // Whole pipeline moves unless the result holds
   assign advance   = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[LAT-1];
   assign valid_in  = {valid_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: scale the odd texel coordinate by the base cell count
   assign prod_x_in = PW'({req_texel_x, 1'b1}) * PW'(cells0);
   assign prod_y_in = PW'({req_texel_y, 1'b1}) * PW'(cells0);

   // Stage 2: base cell index modulo base cells, shared by all octaves
   always_comb begin
      quo[0] = prod_x_ff >> (TILE_LOG + 1);
      quo[1] = prod_y_ff >> (TILE_LOG + 1);
      for (int a = 0; a < 2; a++) begin
         rem_work[a] = quo[a];
         for (int k = REM_STEPS - 1; k >= 0; k--) begin
            if (rem_work[a] >= (PW'(cells0) << k)) begin
               rem_work[a] = rem_work[a] - (PW'(cells0) << k);
            end
         end
      end
      axis_in[0].prod = prod_x_ff;
      axis_in[0].rem  = rem_work[0][BW-1:0];
      axis_in[1].prod = prod_y_ff;
      axis_in[1].rem  = rem_work[1][BW-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         axis_ff   <= axis_in;
      end
   end

   // One lane per octave
   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
      tfbm_octave #(
         .TILE_SIZE   (TILE_SIZE),
         .MAX_OCTAVES (MAX_OCTAVES),
         .OCT_IDX     (i)
      ) u_octave (
         .clock      (clock),
         .enable     (advance),
         .base_count (cells0),
         .axis_x     (axis_ff[0]),
         .axis_y     (axis_ff[1]),
         .blend      (blend[i])
      );
   end

   tfbm_norm #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_norm (
      .clock       (clock),
      .enable      (advance),
      .octaves     (octaves),
      .blend       (blend),
      .noise_level (rsp_noise_level)
   );

endmodule
`default_nettype wire

/* hdl/tfbm_checker.sv */
// Port-level checks for the noise block, bound to the top level.
// Depends on tfbm_pkg and tileable_fbm_value_noise_top port names.
`default_nettype none
module tfbm_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [tfbm_pkg::NOISE_W-1:0] rsp_noise_level
);
   // Held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_noise_level))
      else $error("result changed while stalled");

   // Input side stalls only behind a held result
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready out of step with result side");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind tileable_fbm_value_noise_top tfbm_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_noise_level (rsp_noise_level)
);
`default_nettype wire
